// ===== rtl/ofa_pkg.sv =====
// Shared constants, command codes and control/status types of the fuse array.
package ofa_pkg;

	// Default array geometry
	localparam int DEF_FUSE_BLOCKS     = 3;
	localparam int DEF_BLOCK_BITS      = 2048;
	localparam int DEF_PROTECTED_SLOTS = 4;

	// Row geometry and header test-bit nibble
	localparam int ROW_BITS   = 32;
	localparam int COL_W      = 5;
	localparam int TB_SHIFT   = 28;
	localparam logic [3:0] TB_PATTERN = 4'hA;
	localparam logic [3:0] TB_BLANK   = 4'h0;

	// Field widths
	localparam int IDX_W       = 13;
	localparam int CMD_W       = 2;
	localparam int PASS_W      = 3;
	localparam int PROT_CNT_W  = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 13;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 8;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PROG  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_INIT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROT_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROT_A     = 3'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic clr;       // clearing sweep writes one blank row
		logic load;      // input beat taken
		logic lookup;    // read addressed row, evaluate protection
		logic apply;     // read bit or program bit
		logic chk_read;  // read current block header row
		logic chk_eval;  // evaluate and maybe initialise header nibble
		logic out_load;  // move result into output register
	} ofa_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;  // clearing sweep at final row
		logic chk_last;  // check at final block
	} ofa_sts_t;

endpackage

// ===== rtl/ofa_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module ofa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 192
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/ofa_dp.sv =====
// Datapath: configuration registers, fuse row store, bit access and header check.
module ofa_dp #(
	parameter int FUSE_BLOCKS     = ofa_pkg::DEF_FUSE_BLOCKS,
	parameter int BLOCK_BITS      = ofa_pkg::DEF_BLOCK_BITS,
	parameter int PROTECTED_SLOTS = ofa_pkg::DEF_PROTECTED_SLOTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ofa_pkg::ofa_cmd_t                 cmd,
	output ofa_pkg::ofa_sts_t                 sts,
	input  logic [ofa_pkg::CMD_W-1:0]         in_code,
	input  logic [ofa_pkg::IDX_W-1:0]         in_index,
	input  logic                              cfg_we,
	input  logic [ofa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ofa_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic [ofa_pkg::OUT_TDATA_W-1:0]   out_data
);

	localparam int TOTAL_BITS = FUSE_BLOCKS * BLOCK_BITS;
	localparam int ROWS       = (TOTAL_BITS + ofa_pkg::ROW_BITS - 1) / ofa_pkg::ROW_BITS;
	localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int HDR_W      = $clog2(TOTAL_BITS + 1);
	localparam int BLK_W      = (FUSE_BLOCKS > 1) ? $clog2(FUSE_BLOCKS) : 1;
	localparam int TB_TOP     = ofa_pkg::TB_SHIFT + 3;

	// Configuration registers
	logic                            auto_init_q;
	logic [ofa_pkg::PROT_CNT_W-1:0]  prot_cnt_q;
	logic [ofa_pkg::IDX_W-1:0]       prot_q [PROTECTED_SLOTS];

	// Command and sequencing state
	logic [ofa_pkg::CMD_W-1:0]       code_q;
	logic [ofa_pkg::IDX_W-1:0]       idx_q;
	logic [ROW_W-1:0]                clr_q;
	logic [BLK_W-1:0]                blk_q;
	logic [HDR_W-1:0]                hdr_q;

	// Result and intermediate payload
	logic                            in_range_q;
	logic                            prot_hit_q;
	logic                            bit_q;
	logic                            acc_q;
	logic [ofa_pkg::PASS_W-1:0]      pass_q;
	logic [ofa_pkg::OUT_TDATA_W-1:0] out_q;

	// RAM interface
	logic                            ram_we;
	logic [ROW_W-1:0]                ram_waddr;
	logic [ofa_pkg::ROW_BITS-1:0]    ram_wdata;
	logic                            ram_re;
	logic [ROW_W-1:0]                ram_raddr;
	logic [ofa_pkg::ROW_BITS-1:0]    rd_data;

	logic [ROW_W-1:0]                idx_row;
	logic [ROW_W-1:0]                hdr_row;
	logic [ofa_pkg::ROW_BITS-1:0]    bit_mask;
	logic                            prot_hit;
	logic                            in_range;
	logic [3:0]                      hdr_nib;
	logic                            hdr_blank;
	logic [3:0]                      hdr_new;
	logic                            prog_ok;

	assign idx_row  = ROW_W'(idx_q >> ofa_pkg::COL_W);
	assign hdr_row  = ROW_W'(hdr_q >> ofa_pkg::COL_W);
	assign bit_mask = {{(ofa_pkg::ROW_BITS-1){1'b0}}, 1'b1} << idx_q[ofa_pkg::COL_W-1:0];
	assign in_range = (32'(idx_q) < TOTAL_BITS);
	assign prog_ok  = (code_q == ofa_pkg::CMD_PROG) && in_range_q && !prot_hit_q;

	// Header nibble of the current block; blank ones get the factory pattern when auto-init is on
	assign hdr_nib   = rd_data[TB_TOP:ofa_pkg::TB_SHIFT];
	assign hdr_blank = (hdr_nib == ofa_pkg::TB_BLANK) && auto_init_q;
	assign hdr_new   = hdr_blank ? ofa_pkg::TB_PATTERN : hdr_nib;

	// Protected index match over the slots in use
	always_comb begin
		prot_hit = 1'b0;
		for (int i = 0; i < PROTECTED_SLOTS; i++) begin
			if ((i < int'(prot_cnt_q)) && (prot_q[i] == idx_q)) begin
				prot_hit = 1'b1;
			end
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_init_q <= 1'b1;
			prot_cnt_q  <= '0;
			for (int i = 0; i < PROTECTED_SLOTS; i++) begin
				prot_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == ofa_pkg::CFG_AUTO_INIT) begin
				auto_init_q <= cfg_data[0];
			end
			if (cfg_index == ofa_pkg::CFG_PROT_COUNT) begin
				prot_cnt_q <= cfg_data[ofa_pkg::PROT_CNT_W-1:0];
			end
			for (int i = 0; i < PROTECTED_SLOTS; i++) begin
				if (int'(cfg_index) == int'(ofa_pkg::CFG_PROT_A) + i) begin
					prot_q[i] <= cfg_data;
				end
			end
		end
	end

	// Clearing sweep and check counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			blk_q <= '0;
			hdr_q <= '0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.load) begin
				blk_q <= '0;
				hdr_q <= '0;
			end else if (cmd.chk_eval) begin
				blk_q <= blk_q + 1'b1;
				hdr_q <= hdr_q + HDR_W'(BLOCK_BITS);
			end
		end
	end

	// Item payload and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			code_q <= in_code;
			idx_q  <= in_index;
			bit_q  <= 1'b0;
			acc_q  <= 1'b0;
			pass_q <= '0;
		end
		if (cmd.lookup) begin
			in_range_q <= in_range;
			prot_hit_q <= prot_hit;
		end
		if (cmd.apply) begin
			if (code_q == ofa_pkg::CMD_READ) begin
				bit_q <= rd_data[idx_q[ofa_pkg::COL_W-1:0]] & in_range_q;
			end
			acc_q <= prog_ok;
		end
		if (cmd.chk_eval) begin
			for (int i = 0; i < ofa_pkg::PASS_W; i++) begin
				if ((32'(blk_q) == i) && (hdr_new == ofa_pkg::TB_PATTERN)) begin
					pass_q[i] <= 1'b1;
				end
			end
		end
		if (cmd.out_load) begin
			out_q <= ofa_pkg::OUT_TDATA_W'({pass_q, acc_q, bit_q});
		end
	end

	// Row store port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_row;
		ram_wdata = rd_data | bit_mask;
		if (cmd.clr) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (cmd.apply) begin
			ram_we = prog_ok;
		end else if (cmd.chk_eval) begin
			ram_we    = hdr_blank;
			ram_waddr = hdr_row;
			ram_wdata = rd_data;
			ram_wdata[TB_TOP:ofa_pkg::TB_SHIFT] = ofa_pkg::TB_PATTERN;
		end
	end

	assign ram_re    = cmd.lookup | cmd.chk_read;
	assign ram_raddr = cmd.chk_read ? hdr_row : idx_row;

	ofa_ram #(
		.WIDTH (ofa_pkg::ROW_BITS),
		.DEPTH (ROWS)
	) u_rows (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (rd_data)
	);

	assign sts.clr_last = (clr_q == ROW_W'(ROWS - 1));
	assign sts.chk_last = (blk_q == BLK_W'(FUSE_BLOCKS - 1));
	assign out_data     = out_q;

endmodule

// ===== rtl/ofa_ctrl.sv =====
// Controller: sequences clearing sweep, command steps and the output register.
module ofa_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [ofa_pkg::CMD_W-1:0] s_code,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output ofa_pkg::ofa_cmd_t         cmd,
	input  ofa_pkg::ofa_sts_t         sts
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_APPLY,
		ST_CHK_RD,
		ST_CHK_EVAL,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	// Commands decoded from state
	always_comb begin
		cmd          = '0;
		cmd.clr      = (state_q == ST_CLEAR);
		cmd.load     = (state_q == ST_IDLE) && s_tvalid;
		cmd.lookup   = (state_q == ST_LOOKUP);
		cmd.apply    = (state_q == ST_APPLY);
		cmd.chk_read = (state_q == ST_CHK_RD);
		cmd.chk_eval = (state_q == ST_CHK_EVAL);
		cmd.out_load = (state_q == ST_DONE) && out_free;
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						priority if (s_code == ofa_pkg::CMD_READ ||
						             s_code == ofa_pkg::CMD_PROG) begin
							state_q <= ST_LOOKUP;
						end else if (s_code == ofa_pkg::CMD_CHECK) begin
							state_q <= ST_CHK_RD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					state_q <= ST_DONE;
				end
				ST_CHK_RD: begin
					state_q <= ST_CHK_EVAL;
				end
				ST_CHK_EVAL: begin
					state_q <= sts.chk_last ? ST_DONE : ST_CHK_RD;
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/otp_fuse_array.sv =====
// Top level of the one-time-programmable fuse array.
//
// Slave stream: one beat is one command. s_tuser carries the command code
// (read bit, program bit, check block test bits), s_tdata the fuse bit index.
// Master stream: one result beat per command: bit value, program accepted
// flag and per-block header pass bits.
// Configuration: cfg_valid/cfg_index/cfg_data write the auto-init flag, the
// protected slot count and the protected bit indexes; cfg_ready is always
// high. Write only while no command is in flight.
// Read and program step through lookup (row read), apply (bit read or program)
// and done (result load); a check reads and evaluates each block header in
// turn, one row store access per step. The next command is taken only once
// the result is loaded. An unused command code returns an all-zero result.
// Reset clears the row store with a sweep of one row per cycle over all
// rows (192 by default), during which s_tready stays low.
// A stalled receiver holds the result in the output register; one further
// command is accepted and worked, then waits until that register drains.
module otp_fuse_array #(
	parameter int FUSE_BLOCKS     = ofa_pkg::DEF_FUSE_BLOCKS,
	parameter int BLOCK_BITS      = ofa_pkg::DEF_BLOCK_BITS,
	parameter int PROTECTED_SLOTS = ofa_pkg::DEF_PROTECTED_SLOTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ofa_pkg::IN_TDATA_W-1:0]   s_tdata,   // [12:0] bit_index
	input  logic [ofa_pkg::CMD_W-1:0]        s_tuser,   // [1:0] command
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ofa_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [0] bit_value,
	                                                    // [1] program_accepted,
	                                                    // [4:2] test_bits_pass
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ofa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ofa_pkg::CFG_DATA_W-1:0]   cfg_data
);

	ofa_pkg::ofa_cmd_t cmd;
	ofa_pkg::ofa_sts_t sts;

	assign cfg_ready = 1'b1;

	ofa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_code   (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	ofa_dp #(
		.FUSE_BLOCKS     (FUSE_BLOCKS),
		.BLOCK_BITS      (BLOCK_BITS),
		.PROTECTED_SLOTS (PROTECTED_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_code   (s_tuser),
		.in_index  (s_tdata[ofa_pkg::IDX_W-1:0]),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (m_tdata)
	);

endmodule

// ===== rtl/ofa_chk.sv =====
// Port-level checker of the fuse array, bound to the top level.
module ofa_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [ofa_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input logic                             cfg_valid,
	input logic                             cfg_ready
);

	logic       in_beat;
	logic       out_beat;
	logic [1:0] pend_q;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	// Commands accepted and not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_beat && !out_beat) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_beat && !in_beat) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	// Stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// No result without a command behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("result beat with no command outstanding");

	// At most one command worked while a result waits
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |-> pend_q < 2'd2)
		else $error("command accepted beyond capacity");

	// A result answers one kind of command only, padding stays zero
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($countones({m_tdata[0], m_tdata[1], |m_tdata[4:2]}) <= 1) &&
		             (m_tdata[7:5] == 3'b000))
		else $error("result mixes fields of different commands");

	// Configuration writes are always taken: ready is high whenever valid is
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write not taken");

endmodule

bind otp_fuse_array ofa_chk u_ofa_chk (.*);

// ===== tb/otp_fuse_array_tb.sv =====
// Self-checking stream testbench for the one-time-programmable fuse array.
module otp_fuse_array_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Array geometry at the default parameters
	localparam int TOTAL_BITS = ofa_pkg::DEF_FUSE_BLOCKS * ofa_pkg::DEF_BLOCK_BITS;
	localparam int FUSE_ROWS  = (TOTAL_BITS + ofa_pkg::ROW_BITS - 1) / ofa_pkg::ROW_BITS;
	localparam int MAX_INDEX  = (1 << ofa_pkg::IDX_W) - 1;

	// Spare command code and the remaining guard register indexes
	localparam logic [ofa_pkg::CMD_W-1:0]     CMD_SPARE  = 2'd3;
	localparam logic [ofa_pkg::CFG_IDX_W-1:0] REG_PROT_B = ofa_pkg::CFG_PROT_A + 3'd1;
	localparam logic [ofa_pkg::CFG_IDX_W-1:0] REG_PROT_C = ofa_pkg::CFG_PROT_A + 3'd2;
	localparam logic [ofa_pkg::CFG_IDX_W-1:0] REG_PROT_D = ofa_pkg::CFG_PROT_A + 3'd3;

	localparam int ITEMS_PER_PHASE = 310;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int REPORT_LIMIT    = 10;

	typedef logic [ofa_pkg::IDX_W-1:0] fuse_idx_t;

	typedef struct {
		logic                          bit_value;
		logic                          prog_ok;
		logic [ofa_pkg::PASS_W-1:0]    pass_bits;
	} fuse_result_t;

	// Shadow of the fuse array plus the queue of results still owed by the block
	class fuse_tracker;
		logic [ofa_pkg::ROW_BITS-1:0]   rows [FUSE_ROWS];
		logic                           auto_init;
		logic [ofa_pkg::PROT_CNT_W-1:0] guard_count;
		logic [ofa_pkg::IDX_W-1:0]      guard_idx [ofa_pkg::DEF_PROTECTED_SLOTS];
		fuse_result_t                   owed [$];
		int unsigned                    faults;
		int unsigned                    beats_seen;

		function new();
			foreach (rows[i])
				rows[i] = '0;
			foreach (guard_idx[i])
				guard_idx[i] = '0;
			auto_init   = 1'b1;
			guard_count = '0;
			faults      = 0;
			beats_seen  = 0;
		endfunction

		function void set_register(logic [ofa_pkg::CFG_IDX_W-1:0] idx,
		                           logic [ofa_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				ofa_pkg::CFG_AUTO_INIT:  auto_init   = val[0];
				ofa_pkg::CFG_PROT_COUNT: guard_count = val[ofa_pkg::PROT_CNT_W-1:0];
				ofa_pkg::CFG_PROT_A, REG_PROT_B, REG_PROT_C, REG_PROT_D:
					guard_idx[idx - ofa_pkg::CFG_PROT_A] = val[ofa_pkg::IDX_W-1:0];
				default: ;
			endcase
		endfunction

		// Counts above the slot number use every slot
		function bit is_guarded(logic [ofa_pkg::IDX_W-1:0] idx);
			int unsigned n;
			n = (guard_count > ofa_pkg::DEF_PROTECTED_SLOTS) ?
			    ofa_pkg::DEF_PROTECTED_SLOTS : guard_count;
			for (int i = 0; i < n; i++)
				if (guard_idx[i] == idx)
					return 1'b1;
			return 1'b0;
		endfunction

		// Header walk: fill blank nibbles when enabled, flag those holding the pattern
		function logic [ofa_pkg::PASS_W-1:0] walk_headers();
			logic [ofa_pkg::PASS_W-1:0] pass_bits;
			int unsigned                hrow;
			pass_bits = '0;
			for (int b = 0; b < ofa_pkg::DEF_FUSE_BLOCKS; b++) begin
				hrow = (b * ofa_pkg::DEF_BLOCK_BITS) / ofa_pkg::ROW_BITS;
				if (hrow < FUSE_ROWS) begin
					if (rows[hrow][ofa_pkg::TB_SHIFT +: 4] == ofa_pkg::TB_BLANK && auto_init)
						rows[hrow][ofa_pkg::TB_SHIFT +: 4] = ofa_pkg::TB_PATTERN;
					if (rows[hrow][ofa_pkg::TB_SHIFT +: 4] == ofa_pkg::TB_PATTERN &&
					    b < ofa_pkg::PASS_W)
						pass_bits[b] = 1'b1;
				end
			end
			return pass_bits;
		endfunction

		function void note_command(logic [ofa_pkg::CMD_W-1:0] cmd,
		                           logic [ofa_pkg::IDX_W-1:0] idx);
			fuse_result_t r;
			int unsigned  row;
			r   = '{1'b0, 1'b0, '0};
			row = idx / ofa_pkg::ROW_BITS;
			case (cmd)
				ofa_pkg::CMD_READ:
					if (idx < TOTAL_BITS)
						r.bit_value = rows[row][idx % ofa_pkg::ROW_BITS];
				ofa_pkg::CMD_PROG:
					if (idx < TOTAL_BITS && !is_guarded(idx)) begin
						rows[row][idx % ofa_pkg::ROW_BITS] = 1'b1;
						r.prog_ok = 1'b1;
					end
				ofa_pkg::CMD_CHECK:
					r.pass_bits = walk_headers();
				default: ;
			endcase
			owed.push_back(r);
		endfunction

		function void flag_fault(string what);
			faults++;
			if (faults <= REPORT_LIMIT)
				$display("[%0t] result beat %0d: %s", $realtime, beats_seen, what);
		endfunction

		function void check_result(logic [ofa_pkg::OUT_TDATA_W-1:0] beat);
			fuse_result_t want;
			beats_seen++;
			if (owed.size() == 0) begin
				flag_fault($sformatf("nothing outstanding, got data %02h", beat));
				return;
			end
			want = owed.pop_front();
			if (beat[0] !== want.bit_value || beat[1] !== want.prog_ok ||
			    beat[4:2] !== want.pass_bits)
				flag_fault($sformatf({"expected bit %0b acc %0b pass %03b, ",
				                      "got bit %0b acc %0b pass %03b"},
				                     want.bit_value, want.prog_ok, want.pass_bits,
				                     beat[0], beat[1], beat[4:2]));
		endfunction

		function int unsigned outstanding();
			return owed.size();
		endfunction

		function bit clean();
			return faults == 0 && owed.size() == 0;
		endfunction
	endclass

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [ofa_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
	logic [ofa_pkg::CMD_W-1:0]       s_tuser   = '0;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [ofa_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [ofa_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [ofa_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

	fuse_tracker  board = new();
	int unsigned  send_idle_pct = 25;
	int unsigned  recv_idle_pct = 51;
	bit           hold_off      = 1'b0;
	int unsigned  quiet_cycles  = 0;
	fuse_idx_t    slot_idx [ofa_pkg::DEF_PROTECTED_SLOTS] = '{default: '0};
	fuse_idx_t    last_prog = '0;

	otp_fuse_array i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Beat monitor: results are checked before new commands are noted
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
		if (arst_n && s_tvalid && s_tready)
			board.note_command(s_tuser, s_tdata[ofa_pkg::IDX_W-1:0]);
	end

	// Watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("otp_fuse_array: mismatch");
		$finish;
	end

	// Result sink: random back-pressure, or one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_command(input logic [ofa_pkg::CMD_W-1:0] cmd, input int idx);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= idx[ofa_pkg::IN_TDATA_W-1:0];
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic write_reg(input logic [ofa_pkg::CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[ofa_pkg::CFG_DATA_W-1:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		board.set_register(idx, val[ofa_pkg::CFG_DATA_W-1:0]);
		if (idx >= ofa_pkg::CFG_PROT_A && idx <= REG_PROT_D)
			slot_idx[idx - ofa_pkg::CFG_PROT_A] = val[ofa_pkg::IDX_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.outstanding() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Mostly legal indexes, with a share past the array, on guarded bits and on headers
	function automatic fuse_idx_t pick_index();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 50)
			return fuse_idx_t'($urandom_range(TOTAL_BITS - 1));
		else if (sel < 62)
			return fuse_idx_t'($urandom_range(MAX_INDEX, TOTAL_BITS));
		else if (sel < 74)
			return slot_idx[$urandom_range(ofa_pkg::DEF_PROTECTED_SLOTS - 1)];
		else if (sel < 86)
			return last_prog;
		else
			return fuse_idx_t'($urandom_range(ofa_pkg::DEF_FUSE_BLOCKS - 1) *
			                   ofa_pkg::DEF_BLOCK_BITS +
			                   $urandom_range(ofa_pkg::TB_SHIFT + 3, ofa_pkg::TB_SHIFT));
	endfunction

	function automatic fuse_idx_t pick_guard();
		case ($urandom_range(7))
			0:       return '0;
			1:       return fuse_idx_t'(TOTAL_BITS - 1);
			2:       return fuse_idx_t'($urandom_range(MAX_INDEX));
			default: return fuse_idx_t'($urandom_range(TOTAL_BITS - 1));
		endcase
	endfunction

	task automatic send_random_item();
		logic [ofa_pkg::CMD_W-1:0] cmd;
		fuse_idx_t                 idx;
		int unsigned               sel;
		sel = $urandom_range(99);
		if (sel < 42)
			cmd = ofa_pkg::CMD_READ;
		else if (sel < 84)
			cmd = ofa_pkg::CMD_PROG;
		else if (sel < 94)
			cmd = ofa_pkg::CMD_CHECK;
		else
			cmd = CMD_SPARE;
		idx = pick_index();
		if (cmd == ofa_pkg::CMD_PROG)
			last_prog = idx;
		send_command(cmd, idx);
	endtask

	// Per-phase register settings for the random part
	logic [ofa_pkg::PROT_CNT_W-1:0] phase_count [6] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3};
	logic                           phase_auto  [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Directed, reset settings: guards off, auto-init on
		send_command(ofa_pkg::CMD_READ, 0);
		send_command(ofa_pkg::CMD_READ, TOTAL_BITS - 1);
		send_command(ofa_pkg::CMD_PROG, ofa_pkg::TB_SHIFT);    // block 0 header off-pattern
		send_command(ofa_pkg::CMD_PROG, 2 * ofa_pkg::DEF_BLOCK_BITS + ofa_pkg::TB_SHIFT + 1);
		send_command(ofa_pkg::CMD_PROG, 2 * ofa_pkg::DEF_BLOCK_BITS + ofa_pkg::TB_SHIFT + 3);
		send_command(ofa_pkg::CMD_READ, 2 * ofa_pkg::DEF_BLOCK_BITS + ofa_pkg::TB_SHIFT + 3);
		send_command(ofa_pkg::CMD_READ, MAX_INDEX);            // past the array
		send_command(ofa_pkg::CMD_PROG, TOTAL_BITS);
		send_command(ofa_pkg::CMD_PROG, MAX_INDEX);
		send_command(CMD_SPARE, MAX_INDEX);
		send_command(ofa_pkg::CMD_CHECK, 0);                   // fills blank block 1 only
		send_command(ofa_pkg::CMD_READ, ofa_pkg::DEF_BLOCK_BITS + ofa_pkg::TB_SHIFT + 3);
		send_command(ofa_pkg::CMD_PROG, 0);
		send_command(ofa_pkg::CMD_READ, 0);
		wait_drained();

		// Directed, guards with an oversized count and auto-init off
		write_reg(ofa_pkg::CFG_AUTO_INIT, 0);
		write_reg(ofa_pkg::CFG_PROT_COUNT, 7);
		write_reg(ofa_pkg::CFG_PROT_A, 5);
		write_reg(REG_PROT_B, TOTAL_BITS - 1);
		write_reg(REG_PROT_C, ofa_pkg::DEF_BLOCK_BITS + 20);
		write_reg(REG_PROT_D, MAX_INDEX);
		send_command(ofa_pkg::CMD_PROG, 5);
		send_command(ofa_pkg::CMD_PROG, TOTAL_BITS - 1);
		send_command(ofa_pkg::CMD_PROG, ofa_pkg::DEF_BLOCK_BITS + 20);
		send_command(ofa_pkg::CMD_READ, ofa_pkg::DEF_BLOCK_BITS + 20);
		send_command(ofa_pkg::CMD_PROG, 6);
		send_command(ofa_pkg::CMD_CHECK, MAX_INDEX);           // index has no effect
		send_command(CMD_SPARE, 0);
		send_command(ofa_pkg::CMD_READ, 6);
		wait_drained();

		// Random phases, two per idling mode
		for (int ph = 0; ph < 6; ph++) begin
			case (ph / 2)
				0: begin
					send_idle_pct = 25;
					recv_idle_pct = 51;
				end
				1: begin
					send_idle_pct = 51;
					recv_idle_pct = 25;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			write_reg(ofa_pkg::CFG_AUTO_INIT, phase_auto[ph]);
			write_reg(ofa_pkg::CFG_PROT_COUNT, phase_count[ph]);
			write_reg(ofa_pkg::CFG_PROT_A, pick_guard());
			write_reg(REG_PROT_B, pick_guard());
			write_reg(REG_PROT_C, pick_guard());
			write_reg(REG_PROT_D, pick_guard());
			if (ph == 4)
				hold_off = 1'b1;
			repeat (ITEMS_PER_PHASE)
				send_random_item();
			wait_drained();
		end

		repeat (16) @(negedge clk);
		if (board.clean())
			$display("otp_fuse_array: match");
		else
			$display("otp_fuse_array: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ofa_pkg.sv
rtl/ofa_ram.sv
rtl/ofa_dp.sv
rtl/ofa_ctrl.sv
rtl/otp_fuse_array.sv
rtl/ofa_chk.sv
tb/otp_fuse_array_tb.sv
